// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int SPQ_CAPACITY = 16;
   localparam int KEY_W        = 16;
   localparam int PAYLOAD_W    = 32;
   localparam int COUNT_W      = 5;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic MIN_FIRST_RESET = 1'b1;

   typedef struct packed {
      logic                 valid;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } spq_entry_type;

   // broadcast to every cell for one transaction
   typedef struct packed {
      logic                 push_en;
      logic                 pop_en;
      logic                 min_first;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } spq_ctl_type;

endpackage

// ===== design/spq_ifs.sv =====
// ----------------------------------------------------------------------------
// spq_ifs
// Valid/ready channels of the sorted priority queue.
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [spq_pkg::KEY_W-1:0]     key;
   logic [spq_pkg::PAYLOAD_W-1:0] payload;

   modport source (output valid, operation, key, payload, input ready);
   modport sink   (input valid, operation, key, payload, output ready);
endinterface

interface spq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [spq_pkg::KEY_W-1:0]     head_key;
   logic [spq_pkg::PAYLOAD_W-1:0] head_payload;
   logic                         empty_res;
   logic [spq_pkg::COUNT_W-1:0]   count;
   logic                         overflow;
   logic                         underflow;

   modport source (output valid, head_key, head_payload, empty_res, count, overflow,
                   underflow, input ready);
   modport sink   (input valid, head_key, head_payload, empty_res, count, overflow,
                   underflow, output ready);
endinterface

interface spq_csr_if;
   logic valid;
   logic ready;
   logic min_first;

   modport source (output valid, min_first, input ready);
   modport sink   (input valid, min_first, output ready);
endinterface

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: holds an entry, shifts toward the tail on insert and toward
// the head on removal.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  spq_pkg::spq_ctl_type   ctl,
   input  spq_pkg::spq_entry_type left_entry,
   input  spq_pkg::spq_entry_type right_entry,
   input  logic                   above_in,
   output logic                   above_out,
   output spq_pkg::spq_entry_type entry
);
   import spq_pkg::*;

   logic                 valid_ff, valid_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;
   logic                 ranks_above;

   // held entry strictly outranks the incoming key
   assign ranks_above = valid_ff &&
                        (ctl.min_first ? (key_ff < ctl.key) : (key_ff > ctl.key));
   assign above_out   = above_in && ranks_above;

   always_comb begin
      valid_in   = valid_ff;
      key_in     = key_ff;
      payload_in = payload_ff;
      priority if (ctl.pop_en) begin
         valid_in   = right_entry.valid;
         key_in     = right_entry.key;
         payload_in = right_entry.payload;
      end else if (ctl.push_en && !above_in) begin
         valid_in   = left_entry.valid;
         key_in     = left_entry.key;
         payload_in = left_entry.payload;
      end else if (ctl.push_en && !ranks_above) begin
         valid_in   = 1'b1;
         key_in     = ctl.key;
         payload_in = ctl.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign entry.valid   = valid_ff;
   assign entry.key     = key_ff;
   assign entry.payload = payload_ff;

endmodule

// ===== design/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Every request transaction is a push or a pop and produces one response
// transaction with the head entry, empty flag, entry count and the
// overflow/underflow flags as they stand after the operation. All cells
// compare the new key against their entry in the same cycle and either keep,
// take the new entry or take a neighbor's entry, so a request is taken every
// cycle while the response register is free or being drained. A push goes in
// front of held entries of equal priority. min_first is written through the
// csr channel (always ready); the user must write it only while the queue is
// idle, which the block does not enforce; held entries keep order on a change.
module sorted_priority_queue_unit #(
   parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp,
   spq_csr_if.sink   csr
);
   import spq_pkg::*;

   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                 min_first_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 overflow_ff, underflow_ff;
   logic                 accept, full, empty_q;
   spq_ctl_type          ctl;
   spq_entry_type        cells [CAPACITY];
   logic [CAPACITY:0]    above_chain;
   logic [CNT_W+COUNT_W-1:0] count_ext;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_first_ff <= MIN_FIRST_RESET;
      end else if (csr.valid) begin
         min_first_ff <= csr.min_first;
      end
   end

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty_q   = (count_ff == '0);

   assign ctl.push_en   = accept && (req.operation == OP_PUSH) && !full;
   assign ctl.pop_en    = accept && (req.operation == OP_POP) && !empty_q;
   assign ctl.min_first = min_first_ff;
   assign ctl.key       = req.key;
   assign ctl.payload   = req.payload;

   assign above_chain[0] = 1'b1;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_entry_type left_entry, right_entry;
      if (i == 0) begin : g_head
         assign left_entry = '0;
      end else begin : g_mid
         assign left_entry = cells[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = cells[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .above_in    (above_chain[i]),
         .above_out   (above_chain[i+1]),
         .entry       (cells[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      priority if (ctl.push_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop_en) begin
         count_in = count_ff - CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         overflow_ff  <= (req.operation == OP_PUSH) && full;
         underflow_ff <= (req.operation == OP_POP) && empty_q;
      end
   end

   // queue state only moves on an accepted request, so the head cell and the
   // counter hold the response fields until the next transaction
   assign count_ext        = {{COUNT_W{1'b0}}, count_ff};
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.head_key     = cells[0].valid ? cells[0].key : '0;
   assign rsp.head_payload = cells[0].valid ? cells[0].payload : '0;
   assign rsp.empty_res    = !cells[0].valid;
   assign rsp.count        = count_ext[COUNT_W-1:0];
   assign rsp.overflow     = overflow_ff;
   assign rsp.underflow    = underflow_ff;

   `ASSERT_IMPLIES(a_head_tracks_count, clock, reset, 1'b1, (count_ff == '0) == !cells[0].valid)
   `ASSERT_IMPLIES(a_tail_only_when_full, clock, reset, cells[CAPACITY-1].valid, full)
   `ASSERT_NEXT(a_overflow_keeps_count, clock, reset, accept && (req.operation == OP_PUSH) && full, $stable(count_ff) && overflow_ff)
   `ASSERT_NEXT(a_pop_shrinks, clock, reset, ctl.pop_en, count_ff == $past(count_ff) - CNT_W'(1))

endmodule
